[design/mbps_pkg.sv]
`timescale 1ns / 1ps

package mbps_pkg;

    // Pattern storage is fixed at two 64-bit words of bytes.
    localparam int REG_BYTES       = 16;
    localparam int REG_W           = 64;
    localparam int PATTERN_W       = 8 * REG_BYTES;
    localparam int LENGTH_W        = 5;
    localparam int HIT_OFFSET_W    = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VALUE_LOW  = 3'd0,
        CFG_VALUE_HIGH = 3'd1,
        CFG_MASK_LOW   = 3'd2,
        CFG_MASK_HIGH  = 3'd3,
        CFG_LENGTH     = 3'd4,
        CFG_FIRST_ONLY = 3'd5
    } t_cfg_index;

    // Pattern settings as seen by the compare logic.
    typedef struct packed {
        logic [PATTERN_W-1:0] value;
        logic [PATTERN_W-1:0] mask;
        logic [LENGTH_W-1:0]  length;
        logic                 first_only;
    } t_cfg;

endpackage

[design/mbps_cfg_regs.sv]
`timescale 1ns / 1ps

module mbps_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mbps_pkg::REG_W-1:0]          i_cfg_data,
    output mbps_pkg::t_cfg                      o_cfg
);
    import mbps_pkg::*;

    logic [REG_W-1:0]    r_value_low;
    logic [REG_W-1:0]    r_value_high;
    logic [REG_W-1:0]    r_mask_low;
    logic [REG_W-1:0]    r_mask_high;
    logic [LENGTH_W-1:0] r_length;
    logic                r_first_only;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_low  <= '0;
            r_value_high <= '0;
            r_mask_low   <= '0;
            r_mask_high  <= '0;
            r_length     <= '0;
            r_first_only <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_VALUE_LOW:  r_value_low  <= i_cfg_data;
                CFG_VALUE_HIGH: r_value_high <= i_cfg_data;
                CFG_MASK_LOW:   r_mask_low   <= i_cfg_data;
                CFG_MASK_HIGH:  r_mask_high  <= i_cfg_data;
                CFG_LENGTH:     r_length     <= i_cfg_data[LENGTH_W-1:0];
                CFG_FIRST_ONLY: r_first_only <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.value      = {r_value_high, r_value_low};
    assign o_cfg.mask       = {r_mask_high, r_mask_low};
    assign o_cfg.length     = r_length;
    assign o_cfg.first_only = r_first_only;

endmodule

[design/mbps_window_match.sv]
`timescale 1ns / 1ps

module mbps_window_match #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  mbps_pkg::t_cfg                  i_cfg,
    input  logic [MAX_PATTERN-1:0][7:0]     i_window,
    output logic                            o_match
);
    import mbps_pkg::*;

    localparam int NLANES = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int TAP_W  = IDX_W + 2;

    logic [NLANES-1:0] lane_ok;
    logic              len_ok;

    // One masked compare per pattern byte; pattern byte j meets the window
    // byte that arrived length-1-j bytes ago.
    always_comb begin
        logic [TAP_W-1:0] tap;
        logic [7:0]       pat_v;
        logic [7:0]       pat_m;
        logic [7:0]       dat;
        tap = '0;
        for (int j = 0; j < NLANES; j++) begin
            tap   = TAP_W'(i_cfg.length) - TAP_W'(j) - TAP_W'(1);
            pat_v = i_cfg.value[8*j +: 8];
            pat_m = i_cfg.mask[8*j +: 8];
            dat   = i_window[tap[IDX_W-1:0]];
            if (j < int'(i_cfg.length)) begin
                lane_ok[j] = ((dat & pat_m) == (pat_v & pat_m));
            end else begin
                lane_ok[j] = 1'b1;
            end
        end
    end

    // Zero length and lengths beyond the stored pattern or the window never match.
    assign len_ok = (i_cfg.length != '0)
                 && (int'(i_cfg.length) <= REG_BYTES)
                 && (int'(i_cfg.length) <= MAX_PATTERN);

    assign o_match = len_ok && (&lane_ok);

endmodule

[design/masked_byte_pattern_scanner_core.sv]
`timescale 1ns / 1ps

// Masked byte pattern scanner. Each accepted request carries one byte of a
// buffer; the block answers every byte with one result that says whether the
// last pattern_length bytes of the current buffer match the masked pattern,
// and where that match starts. The block takes one byte per clock cycle
// while results are taken; a result that is not taken stalls the input. A
// byte passes the input register, then one pass of up to sixteen parallel
// masked compares into the result register. Windows never span two buffers;
// the request with end_of_buffer set also reports whether the buffer held
// any match and starts a new buffer. The byte counter saturates, and no
// match is reported once it has. Configuration is written through a plain
// write port and must only change while no request is in flight. There is
// no clearing pass after reset.
module masked_byte_pattern_scanner_core #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mbps_pkg::REG_W-1:0]          i_cfg_data,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_end_of_buffer,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic [mbps_pkg::HIT_OFFSET_W-1:0]   o_hit_offset,
    output logic                                o_buffer_done,
    output logic                                o_found_any
);
    import mbps_pkg::*;

    localparam int OFF_EXT_W = (OFFSET_BITS > HIT_OFFSET_W) ? OFFSET_BITS : HIT_OFFSET_W;

    t_cfg cfg;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Scan state
    logic [MAX_PATTERN-1:0][7:0] r_window;
    logic [MAX_PATTERN-1:0][7:0] n_window;
    logic [OFFSET_BITS-1:0]      r_count;
    logic [OFFSET_BITS-1:0]      n_count;
    logic                        r_found;
    logic                        n_found;

    // Result register
    logic                        r_out_valid;
    logic                        r_hit;
    logic [HIT_OFFSET_W-1:0]     r_hit_offset;
    logic                        r_buffer_done;
    logic                        r_found_any;

    logic                        out_free;
    logic                        advance;
    logic                        accept_in;
    logic                        saturated;
    logic                        window_match;
    logic                        match;
    logic                        hit;
    logic [OFFSET_BITS-1:0]      offset;
    logic [OFF_EXT_W-1:0]        offset_ext;

    mbps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: the result register frees itself when taken, and the input
    // register moves on whenever the result register can take its answer.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign accept_in  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_buffer;
        end
    end

    // Window shifts in the new byte, newest at position zero.
    always_comb begin
        n_window[0] = r_in_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_window[i] = r_window[i-1];
        end
    end

    mbps_window_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window_match (
        .i_cfg    (cfg),
        .i_window (n_window),
        .o_match  (window_match)
    );

    // Byte count, match qualification and found flag.
    assign saturated = (r_count == {OFFSET_BITS{1'b1}});

    always_comb begin
        n_count    = saturated ? r_count : r_count + OFFSET_BITS'(1);
        match      = !saturated && window_match
                  && (n_count >= OFFSET_BITS'(cfg.length));
        offset     = n_count - OFFSET_BITS'(cfg.length);
        offset_ext = OFF_EXT_W'(offset);
        hit        = match && !(cfg.first_only && r_found);
        n_found    = r_found || match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_count <= '0;
                r_found <= 1'b0;
            end else begin
                r_count <= n_count;
                r_found <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_window <= n_window;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hit         <= hit;
            r_hit_offset  <= hit ? offset_ext[HIT_OFFSET_W-1:0] : '0;
            r_buffer_done <= r_in_last;
            r_found_any   <= r_in_last && n_found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_hit_offset  = r_hit_offset;
    assign o_buffer_done = r_buffer_done;
    assign o_found_any   = r_found_any;

`ifndef ASSERT_OFF
    // A hit on the last byte of a buffer must show up in the summary flag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit && o_buffer_done) |-> o_found_any)
        else $error("hit on last byte without found_any");

    // The summary flag only appears on the last result of a buffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found_any) |-> o_buffer_done)
        else $error("found_any outside end of buffer");

    // A result without a hit carries a zero offset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_hit_offset == '0))
        else $error("nonzero offset without hit");

    // The byte counter never wraps back to zero inside a buffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_last) |=> (r_count != '0))
        else $error("byte counter wrapped");
`endif

endmodule
